FILE: design/mspid_pkg.sv
// shared types, constants and reset values for the pid speed controller
package mspid_pkg;

  localparam int TickW    = 16;
  localparam int TargetW  = 14;
  localparam int AngleW   = 10;
  localparam int GainW    = 24;
  localparam int PulseW   = 16;
  localparam int MeasW    = 24;
  localparam int ErrW     = 32;
  localparam int SumW     = 40;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 24;
  localparam int MulW     = 32;
  localparam int ProdW    = 64;

  localparam logic [GainW-1:0]  PropGainRst   = 24'd78643;
  localparam logic [GainW-1:0]  IntegGainRst  = 24'd32768;
  localparam logic [GainW-1:0]  DerivGainRst  = 24'd655;
  localparam logic [PulseW-1:0] PulseMinRst   = 16'd1000;
  localparam logic [PulseW-1:0] PulseMaxRst   = 16'd2000;
  localparam logic [PulseW-1:0] CenterRst     = 16'd1500;
  localparam logic [PulseW-1:0] SteerGainRst  = 16'd4250;
  localparam logic [PulseW-1:0] SpeedScaleRst = 16'd15841;

  // x / 100 for any 32-bit unsigned x is (x * DivMagic) >> DivShift
  localparam logic [MulW-1:0]  DivMagic    = 32'h51EB_851F;
  localparam int               DivShift    = 37;
  localparam logic [MulW-1:0]  DerivScale  = 32'd100;
  localparam logic [ProdW-1:0] ProdLimit   = 64'h2000_0000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    RegPropGain   = 4'd0,
    RegIntegGain  = 4'd1,
    RegDerivGain  = 4'd2,
    RegPulseMin   = 4'd3,
    RegPulseMax   = 4'd4,
    RegCenter     = 4'd5,
    RegSteerGain  = 4'd6,
    RegSpeedScale = 4'd7
  } mspid_reg_e;

  typedef enum logic [4:0] {
    StIdle,
    StSpd,
    StSpdCap,
    StSteerCap,
    StErr,
    StDiv,
    StDivCap,
    StDiff,
    StDiffCap,
    StTermLo,
    StTermHi,
    StTermSum,
    StTermAcc,
    StClampHi,
    StClampLo,
    StOut
  } mspid_state_e;

  typedef enum logic [3:0] {
    OpNone,
    OpLatch,
    OpSpeedCap,
    OpSteerCap,
    OpErr,
    OpEsum,
    OpDeriv,
    OpTermLo,
    OpTermSum,
    OpTermAcc,
    OpClampHi,
    OpClampLo,
    OpOut
  } mspid_op_e;

  typedef enum logic [2:0] {
    MulNone,
    MulSpeed,
    MulSteer,
    MulDiv,
    MulDiff,
    MulTermLo,
    MulTermHi
  } mspid_mul_e;

  typedef enum logic [1:0] {
    TermProp,
    TermInteg,
    TermDeriv
  } mspid_term_e;

  typedef struct packed {
    mspid_op_e   op;
    mspid_mul_e  mul;
    mspid_term_e term;
  } mspid_cmd_t;

  typedef struct packed {
    logic target_zero;
  } mspid_stat_t;

endpackage

FILE: design/mspid_if.sv
// valid/ready channel interfaces for input beats, result beats and register writes
interface mspid_in_if;
  import mspid_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [TickW-1:0]   encoder_delta;
  logic signed [TargetW-1:0] speed_target;
  logic signed [AngleW-1:0]  steer_angle;
  modport source (output valid, encoder_delta, speed_target, steer_angle, input ready);
  modport sink   (input valid, encoder_delta, speed_target, steer_angle, output ready);
endinterface

interface mspid_out_if;
  import mspid_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [PulseW-1:0]       motor_pulse;
  logic [PulseW-1:0]       steer_pulse;
  logic signed [MeasW-1:0] measured_speed;
  modport source (output valid, motor_pulse, steer_pulse, measured_speed, input ready);
  modport sink   (input valid, motor_pulse, steer_pulse, measured_speed, output ready);
endinterface

interface mspid_cfg_if;
  import mspid_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/mspid_ctrl.sv
// sequencer that walks one control tick through the shared multiplier datapath
module mspid_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  mspid_pkg::mspid_stat_t stat_i,
  output mspid_pkg::mspid_cmd_t  cmd_o
);
  import mspid_pkg::*;

  mspid_state_e state_q, state_d;
  mspid_term_e  term_q, term_d;
  logic         out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      term_q      <= TermProp;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    term_d      = term_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = OpNone;
    cmd_o.mul   = MulNone;
    cmd_o.term  = term_q;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OpLatch;
          state_d  = StSpd;
        end
      end
      StSpd: begin
        cmd_o.mul = MulSpeed;
        state_d   = StSpdCap;
      end
      StSpdCap: begin
        cmd_o.op  = OpSpeedCap;
        cmd_o.mul = MulSteer;
        state_d   = StSteerCap;
      end
      StSteerCap: begin
        cmd_o.op = OpSteerCap;
        state_d  = StErr;
      end
      StErr: begin
        cmd_o.op = OpErr;
        state_d  = stat_i.target_zero ? StOut : StDiv;
      end
      StDiv: begin
        cmd_o.mul = MulDiv;
        state_d   = StDivCap;
      end
      StDivCap: begin
        cmd_o.op = OpEsum;
        state_d  = StDiff;
      end
      StDiff: begin
        cmd_o.mul = MulDiff;
        state_d   = StDiffCap;
      end
      StDiffCap: begin
        cmd_o.op = OpDeriv;
        term_d   = TermProp;
        state_d  = StTermLo;
      end
      StTermLo: begin
        cmd_o.mul = MulTermLo;
        state_d   = StTermHi;
      end
      StTermHi: begin
        cmd_o.mul = MulTermHi;
        cmd_o.op  = OpTermLo;
        state_d   = StTermSum;
      end
      StTermSum: begin
        cmd_o.op = OpTermSum;
        state_d  = StTermAcc;
      end
      StTermAcc: begin
        cmd_o.op = OpTermAcc;
        if (term_q == TermDeriv) begin
          state_d = StClampHi;
        end else begin
          term_d  = (term_q == TermProp) ? TermInteg : TermDeriv;
          state_d = StTermLo;
        end
      end
      StClampHi: begin
        cmd_o.op = OpClampHi;
        state_d  = StClampLo;
      end
      StClampLo: begin
        cmd_o.op = OpClampLo;
        state_d  = StOut;
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OpOut;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StSpd))
    else $error("accepted beat did not start the speed product");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StOut))
    else $error("result beat raised outside the output step");

  a_last_term_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTermAcc && term_q == TermDeriv) |=> (state_q == StClampHi))
    else $error("derivative term not followed by the clamp");

endmodule

FILE: design/mspid_dp.sv
// datapath: config registers, shared multiplier, pid state and result registers
module mspid_dp (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [mspid_pkg::CfgIdxW-1:0]            cfg_idx_i,
  input  logic [mspid_pkg::CfgDataW-1:0]           cfg_data_i,
  input  logic signed [mspid_pkg::TickW-1:0]       encoder_delta_i,
  input  logic signed [mspid_pkg::TargetW-1:0]     speed_target_i,
  input  logic signed [mspid_pkg::AngleW-1:0]      steer_angle_i,
  input  mspid_pkg::mspid_cmd_t                    cmd_i,
  output mspid_pkg::mspid_stat_t                   stat_o,
  output logic [mspid_pkg::PulseW-1:0]             motor_pulse_o,
  output logic [mspid_pkg::PulseW-1:0]             steer_pulse_o,
  output logic signed [mspid_pkg::MeasW-1:0]       measured_speed_o
);
  import mspid_pkg::*;

  // configuration registers
  logic [GainW-1:0]  prop_q, integ_q, deriv_q;
  logic [PulseW-1:0] pmin_q, pmax_q, center_q, sgain_q, scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q   <= PropGainRst;
      integ_q  <= IntegGainRst;
      deriv_q  <= DerivGainRst;
      pmin_q   <= PulseMinRst;
      pmax_q   <= PulseMaxRst;
      center_q <= CenterRst;
      sgain_q  <= SteerGainRst;
      scale_q  <= SpeedScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPropGain:   prop_q   <= cfg_data_i;
        RegIntegGain:  integ_q  <= cfg_data_i;
        RegDerivGain:  deriv_q  <= cfg_data_i;
        RegPulseMin:   pmin_q   <= cfg_data_i[PulseW-1:0];
        RegPulseMax:   pmax_q   <= cfg_data_i[PulseW-1:0];
        RegCenter:     center_q <= cfg_data_i[PulseW-1:0];
        RegSteerGain:  sgain_q  <= cfg_data_i[PulseW-1:0];
        RegSpeedScale: scale_q  <= cfg_data_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  // pid state
  logic signed [SumW-1:0] esum_q;
  logic signed [ErrW-1:0] last_q;

  // working registers
  logic signed [TickW-1:0]   tick_q;
  logic signed [TargetW-1:0] tgt_q;
  logic signed [AngleW-1:0]  ang_q;
  logic signed [ErrW-1:0]    speed_q;
  logic signed [MeasW-1:0]   meas_q;
  logic [PulseW-1:0]         steer_q;
  logic signed [ErrW-1:0]    err_q;
  logic [ErrW-1:0]           dabs_q;
  logic                      dsign_q;
  logic [SumW-1:0]           dmag_q;
  logic [ProdW-1:0]          prod_q;
  logic signed [ProdW-1:0]   acc_q;
  logic [ProdW-1:0]          mul_q;

  // result registers
  logic [PulseW-1:0]       out_motor_q, out_steer_q;
  logic signed [MeasW-1:0] out_meas_q;

  // magnitudes for the unsigned multiplier
  logic [TickW:0]   tick_mag;
  logic [AngleW:0]  ang_mag;
  logic [ErrW-1:0]  err_mag;
  logic [SumW-1:0]  esum_mag;

  assign tick_mag = tick_q[TickW-1] ? ((TickW+1)'(0) - {tick_q[TickW-1], tick_q})
                                    : {1'b0, tick_q};
  assign ang_mag  = ang_q[AngleW-1] ? ((AngleW+1)'(0) - {ang_q[AngleW-1], ang_q})
                                    : {1'b0, ang_q};
  assign err_mag  = err_q[ErrW-1] ? (ErrW'(0) - err_q) : err_q;
  assign esum_mag = esum_q[SumW-1] ? (SumW'(0) - esum_q) : esum_q;

  // operands of the current pid term
  logic [SumW-1:0]  tmag;
  logic             tsign;
  logic [GainW-1:0] tgain;

  always_comb begin
    unique case (cmd_i.term)
      TermProp: begin
        tmag  = {8'd0, err_mag};
        tsign = err_q[ErrW-1];
        tgain = prop_q;
      end
      TermInteg: begin
        tmag  = esum_mag;
        tsign = esum_q[SumW-1];
        tgain = integ_q;
      end
      TermDeriv: begin
        tmag  = dmag_q;
        tsign = dsign_q;
        tgain = deriv_q;
      end
      default: begin
        tmag  = '0;
        tsign = 1'b0;
        tgain = '0;
      end
    endcase
  end

  // shared 32x32 multiplier, registered
  logic [MulW-1:0] mul_a, mul_b;

  always_comb begin
    unique case (cmd_i.mul)
      MulSpeed: begin
        mul_a = {15'd0, tick_mag};
        mul_b = {16'd0, scale_q};
      end
      MulSteer: begin
        mul_a = {21'd0, ang_mag};
        mul_b = {16'd0, sgain_q};
      end
      MulDiv: begin
        mul_a = err_mag;
        mul_b = DivMagic;
      end
      MulDiff: begin
        mul_a = dabs_q;
        mul_b = DerivScale;
      end
      MulTermLo: begin
        mul_a = tmag[MulW-1:0];
        mul_b = {8'd0, tgain};
      end
      MulTermHi: begin
        mul_a = {24'd0, tmag[SumW-1:MulW]};
        mul_b = {8'd0, tgain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= ProdW'(mul_a) * ProdW'(mul_b);
  end

  // per-step arithmetic
  logic [ErrW-1:0]         spd_p;
  logic [29:0]             st_base, st_prod, st_sum;
  logic [32:0]             err_raw;
  logic [ErrW-1:0]         err_sat;
  logic [26:0]             quot;
  logic [SumW:0]           quot_s, esum_raw;
  logic [SumW-1:0]         esum_sat;
  logic [32:0]             diff;
  logic signed [ProdW-1:0] term_p;
  logic signed [ProdW-1:0] clamp_hi, clamp_lo;

  always_comb begin
    spd_p   = mul_q[ErrW-1:0];
    st_base = {2'b00, center_q, 12'd0};
    st_prod = {5'd0, mul_q[24:0]};
    st_sum  = ang_q[AngleW-1] ? (st_base - st_prod) : (st_base + st_prod);

    err_raw = {{11{tgt_q[TargetW-1]}}, tgt_q, 8'd0} - {speed_q[ErrW-1], speed_q};
    if (err_raw[32] != err_raw[31]) begin
      err_sat = err_raw[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      err_sat = err_raw[31:0];
    end

    quot   = mul_q[ProdW-1:DivShift];
    quot_s = err_q[ErrW-1] ? ((SumW+1)'(0) - {14'd0, quot}) : {14'd0, quot};
    esum_raw = {esum_q[SumW-1], esum_q} + quot_s;
    if (esum_raw[SumW] != esum_raw[SumW-1]) begin
      esum_sat = esum_raw[SumW] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      esum_sat = esum_raw[SumW-1:0];
    end

    diff = {err_q[ErrW-1], err_q} - {last_q[ErrW-1], last_q};

    term_p   = (prod_q > ProdLimit) ? ProdLimit : prod_q;
    clamp_hi = {24'd0, pmax_q, 24'd0};
    clamp_lo = {24'd0, pmin_q, 24'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q <= '0;
      last_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OpErr: begin
          if (tgt_q == '0) begin
            esum_q <= '0;
          end
        end
        OpEsum: begin
          esum_q <= esum_sat;
          last_q <= err_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpLatch: begin
        tick_q <= encoder_delta_i;
        tgt_q  <= speed_target_i;
        ang_q  <= steer_angle_i;
      end
      OpSpeedCap: begin
        speed_q <= tick_q[TickW-1] ? (ErrW'(0) - spd_p) : spd_p;
        meas_q  <= tick_q[TickW-1] ? (MeasW'(0) - {1'b0, spd_p[30:8]})
                                   : {1'b0, spd_p[30:8]};
      end
      OpSteerCap: begin
        if (st_sum[29]) begin
          steer_q <= '0;
        end else if (st_sum[28]) begin
          steer_q <= '1;
        end else begin
          steer_q <= st_sum[27:12];
        end
      end
      OpErr: begin
        err_q <= err_sat;
        acc_q <= '0;
      end
      OpEsum: begin
        dsign_q <= diff[32];
        dabs_q  <= diff[32] ? ErrW'(33'd0 - diff) : diff[31:0];
      end
      OpDeriv: begin
        dmag_q <= mul_q[SumW-1:0];
      end
      OpTermLo: begin
        prod_q <= mul_q;
      end
      OpTermSum: begin
        prod_q <= prod_q + {mul_q[MulW-1:0], 32'd0};
      end
      OpTermAcc: begin
        acc_q <= tsign ? (acc_q - term_p) : (acc_q + term_p);
      end
      OpClampHi: begin
        if (acc_q > clamp_hi) begin
          acc_q <= clamp_hi;
        end
      end
      OpClampLo: begin
        if (acc_q < clamp_lo) begin
          acc_q <= clamp_lo;
        end
      end
      OpOut: begin
        out_motor_q <= (tgt_q == '0) ? center_q : acc_q[39:24];
        out_steer_q <= steer_q;
        out_meas_q  <= meas_q;
      end
      default: ;
    endcase
  end

  assign stat_o.target_zero = (tgt_q == '0);
  assign motor_pulse_o      = out_motor_q;
  assign steer_pulse_o      = out_steer_q;
  assign measured_speed_o   = out_meas_q;

  a_clamped_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OpOut && tgt_q != '0) |-> (acc_q[ProdW-1:40] == '0))
    else $error("clamped pid sum outside the pulse range");

  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OpEsum) |-> (mul_q[ProdW-1:62] == '0))
    else $error("error quotient wider than expected");

  a_deriv_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OpDeriv) |-> (mul_q[ProdW-1:39] == '0))
    else $error("derivative product wider than expected");

endmodule

FILE: design/motor_speed_pid_with_steering.sv
// top level of the motor speed pid controller with steering pulse
// One input beat (encoder ticks, target speed, steering angle) yields one result beat (motor
// pulse, steering pulse, measured speed). All products go through one shared 32x32 multiplier
// that a sequencer walks through up to 23 steps, and a new beat is accepted only once it is back
// in idle; an item with a zero target (stop: center pulse, integral cleared) skips the division,
// derivative, term and clamp steps; the output step waits only while an earlier result
// is still untaken. The finished result sits in an output register, so the next beat is
// accepted while the last result still waits to be taken. Registers are written through the
// config channel, which is always ready; writes are meant to happen while idle.
module motor_speed_pid_with_steering (
  input  logic     clk_i,
  input  logic     rst_ni,
  mspid_in_if.sink    in_i,
  mspid_out_if.source out_o,
  mspid_cfg_if.sink   cfg_i
);
  import mspid_pkg::*;

  // command and status between sequencer and datapath
  mspid_cmd_t  cmd;
  mspid_stat_t stat;

  // register writes never stall
  assign cfg_i.ready = 1'b1;

  // sequencer: one step per state, output beat held until taken
  mspid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: config, multiplier, integral and last error, result registers
  mspid_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_i.valid),
    .cfg_idx_i        (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .encoder_delta_i  (in_i.encoder_delta),
    .speed_target_i   (in_i.speed_target),
    .steer_angle_i    (in_i.steer_angle),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .motor_pulse_o    (out_o.motor_pulse),
    .steer_pulse_o    (out_o.steer_pulse),
    .measured_speed_o (out_o.measured_speed)
  );

endmodule
